FILE: rtl/btc_pkg.sv
// ----------------------------------------------------------------------------
// btc_pkg: shared types and helpers for the transitive closure block
// Row widths, counter widths, the per-cell control word and the decode of
// the state_bits register into last row index and row mask.
// ----------------------------------------------------------------------------
package btc_pkg;

    localparam int MAX_STATES = 16;
    localparam int ROW_W      = MAX_STATES;
    localparam int IDX_W      = $clog2(MAX_STATES);
    localparam int SB_W       = 3;
    localparam int STATE_W    = 2;

    localparam logic [SB_W-1:0] SB_RESET = SB_W'(4);
    localparam logic [SB_W-1:0] SB_MAX   = SB_W'(IDX_W);

    // controller state codes
    localparam logic [STATE_W-1:0] ST_LOAD  = 2'd0;
    localparam logic [STATE_W-1:0] ST_CLOSE = 2'd1;
    localparam logic [STATE_W-1:0] ST_EMIT  = 2'd2;

    typedef logic [ROW_W-1:0] row_t;
    typedef logic [IDX_W-1:0] idx_t;

    // control word broadcast along the row of cells
    typedef struct packed {
        logic shift;   // every cell takes its neighbor's row
        logic close;   // apply the current pivot row
        logic load;    // tail cell takes the incoming word
        idx_t k;       // pivot column / incoming row number
    } cell_ctrl_t;

    // last active row index: N = 2^sb, sb of zero treated as one, N saturates
    function automatic idx_t last_index(input logic [SB_W-1:0] sb);
        logic [SB_W-1:0] s;
        idx_t            one;
        s   = sb;
        one = idx_t'(1);
        if (s == '0) begin
            s = SB_W'(1);
        end
        if (s >= SB_MAX) begin
            return '1;
        end
        return idx_t'((one << s) - one);
    endfunction

    // ones on every column up to and including the last active index
    function automatic row_t row_mask(input idx_t last);
        row_t m;
        for (int j = 0; j < ROW_W; j++) begin
            m[j] = (idx_t'(j) <= last);
        end
        return m;
    endfunction

endpackage

FILE: rtl/btc_cell.sv
// ----------------------------------------------------------------------------
// btc_cell: one matrix row of the closure chain
// Holds a row, ORs in the broadcast pivot row when its own pivot column bit
// is set, and passes the updated row on to its neighbor on every shift.
// ----------------------------------------------------------------------------
module btc_cell
    import btc_pkg::*;
(
    input  logic       aclk,
    input  cell_ctrl_t ctrl,
    input  row_t       pivot_row,
    input  row_t       in_row,
    output row_t       raw_row,
    output row_t       upd_row
);

    row_t row_reg;

    // merge the pivot row when this row reaches the pivot state
    always_comb begin
        upd_row = row_reg;
        if (ctrl.close && row_reg[ctrl.k]) begin
            upd_row = row_reg | pivot_row;
        end
    end

    // advance the chain
    always_ff @(posedge aclk) begin
        if (ctrl.shift) begin
            row_reg <= in_row;
        end
    end

    assign raw_row = row_reg;

endmodule

FILE: rtl/btc_ctrl.sv
// ----------------------------------------------------------------------------
// btc_ctrl: sequencer and output register of the closure block
// Steps through loading, one pivot per cycle, and emitting rows from the
// head of the chain into the result register.
// ----------------------------------------------------------------------------
module btc_ctrl
    import btc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       cfg_write,
    input  idx_t       last_idx,
    input  row_t       head_row,
    output cell_ctrl_t ctrl,
    output logic       m_valid,
    input  logic       m_ready,
    output row_t       m_closure_row,
    output idx_t       m_row_index,
    output logic       m_last_row
);

    logic [STATE_W-1:0] state_reg, state_next;
    idx_t               cnt_reg, cnt_next;
    logic               m_valid_reg, m_valid_next;
    row_t               out_row_reg;
    idx_t               out_idx_reg;
    logic               out_last_reg;
    logic               out_free;
    logic               out_load;
    logic               cnt_end;

    assign out_free = !m_valid_reg || m_ready;
    assign cnt_end  = (cnt_reg == last_idx);
    assign s_ready  = (state_reg == ST_LOAD);

    // decode state into chain control
    always_comb begin
        ctrl       = '0;
        ctrl.k     = cnt_reg;
        state_next = state_reg;
        cnt_next   = cnt_reg;
        out_load   = 1'b0;
        unique case (state_reg)
            ST_LOAD: begin
                if (s_valid) begin
                    ctrl.shift = 1'b1;
                    ctrl.load  = 1'b1;
                    cnt_next   = cnt_end ? '0 : cnt_reg + idx_t'(1);
                    if (cnt_end) begin
                        state_next = ST_CLOSE;
                    end
                end
            end
            ST_CLOSE: begin
                ctrl.shift = 1'b1;
                ctrl.close = 1'b1;
                cnt_next   = cnt_end ? '0 : cnt_reg + idx_t'(1);
                if (cnt_end) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    ctrl.shift = 1'b1;
                    out_load   = 1'b1;
                    cnt_next   = cnt_end ? '0 : cnt_reg + idx_t'(1);
                    if (cnt_end) begin
                        state_next = ST_LOAD;
                    end
                end
            end
            default: begin
                state_next = ST_LOAD;
                cnt_next   = '0;
            end
        endcase
        // drop any partial matrix on a register write
        if (cfg_write) begin
            state_next = ST_LOAD;
            cnt_next   = '0;
        end
    end

    // hold the result word until taken
    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_LOAD;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_row_reg  <= head_row;
            out_idx_reg  <= cnt_reg;
            out_last_reg <= cnt_end;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_closure_row = out_row_reg;
    assign m_row_index   = out_idx_reg;
    assign m_last_row    = out_last_reg;

    // counter never runs past the active matrix size
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= last_idx)
        else $error("row counter beyond last active row");

    // final loaded word starts the closure
    a_load_to_close: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_LOAD && s_valid && cnt_end && !cfg_write)
        |=> (state_reg == ST_CLOSE && cnt_reg == '0))
        else $error("closure did not start after last row");

    // final emitted word returns to loading
    a_emit_to_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT && out_load && cnt_end && !cfg_write)
        |=> (state_reg == ST_LOAD && m_valid && m_last_row))
        else $error("last row not flagged at end of emit");

endmodule

FILE: rtl/boolean_transitive_closure.sv
// N = 2^state_bits (2..16) words load one per cycle while s_valid is held;
// the closure follows, one pivot per cycle as the rows rotate through the
// chain, then N result words leave at up to one per cycle; the first result
// is registered from the head of the chain once the closure has ended.
// Reset (aresetn low, synchronous) clears the sequencer and the result valid
// and sets state_bits to 4; the row chain itself is not cleared.
// ----------------------------------------------------------------------------
// boolean_transitive_closure: Warshall closure over a chain of row cells
// Rows enter at the tail of a ring of cells, rotate once per pivot while the
// head row is broadcast as the pivot, and rotate out from the head.
// ----------------------------------------------------------------------------
module boolean_transitive_closure
    import btc_pkg::*;
(
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic [SB_W-1:0] cfg_state_bits,
    input  logic            s_valid,
    output logic            s_ready,
    input  logic [15:0]     s_row_bits,
    output logic            m_valid,
    input  logic            m_ready,
    output logic [15:0]     m_closure_row,
    output logic [3:0]      m_row_index,
    output logic            m_last_row
);

    logic [SB_W-1:0] state_bits_reg;
    logic            cfg_write;
    idx_t            last_idx;
    row_t            mask;
    row_t            entry_row;
    cell_ctrl_t      ctrl;
    row_t            raw_rows [MAX_STATES];
    row_t            upd_rows [MAX_STATES];
    row_t            in_rows  [MAX_STATES];
    row_t            tail_row;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    // hold the configured matrix size
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_bits_reg <= SB_RESET;
        end else if (cfg_write) begin
            state_bits_reg <= cfg_state_bits;
        end
    end

    assign last_idx = last_index(state_bits_reg);
    assign mask     = row_mask(last_idx);

    // mask the incoming word and set its diagonal bit
    assign entry_row = (s_row_bits & mask) | (row_t'(1) << ctrl.k);
    assign tail_row  = ctrl.load ? entry_row : upd_rows[0];

    // wire the ring: each cell takes its upper neighbor, the last active wraps
    for (genvar i = 0; i < MAX_STATES; i++) begin : g_chain
        if (i == MAX_STATES - 1) begin : g_top
            assign in_rows[i] = tail_row;
        end else begin : g_mid
            assign in_rows[i] = (idx_t'(i) == last_idx) ? tail_row : upd_rows[i+1];
        end
        btc_cell u_cell (
            .aclk      (aclk),
            .ctrl      (ctrl),
            .pivot_row (raw_rows[0]),
            .in_row    (in_rows[i]),
            .raw_row   (raw_rows[i]),
            .upd_row   (upd_rows[i])
        );
    end

    btc_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .cfg_write     (cfg_write),
        .last_idx      (last_idx),
        .head_row      (raw_rows[0]),
        .ctrl          (ctrl),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_closure_row (m_closure_row),
        .m_row_index   (m_row_index),
        .m_last_row    (m_last_row)
    );

endmodule

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for boolean_transitive_closure
// Streams adjacency rows into the block under random valid/ready idling,
// keeps a Warshall closure of its own for every completed matrix, and checks
// each closure word that leaves the block in order, field by field.
// ----------------------------------------------------------------------------
module tb_top;
    import btc_pkg::*;

    localparam int SETTLE_CYCLES  = 64;    // covers load, closure and drain of 16 rows
    localparam int WATCHDOG_LIMIT = 2000;  // cycles without any accepted word
    localparam int PHASE_ROWS     = 167;

    typedef struct packed {
        row_t       reach;
        logic [3:0] src;
        logic       last;
    } closure_word_t;

    // Track the matrix being loaded and the closure words still owed.
    class closure_board;
        logic [SB_W-1:0] size_log;
        int unsigned     rows_held;
        row_t            adj [MAX_STATES];
        closure_word_t   reach_q [$];
        int unsigned     errors;
        int unsigned     rows_in;
        int unsigned     words_out;
        int unsigned     cfg_writes;

        function new();
            size_log   = SB_RESET;
            rows_held  = 0;
            errors     = 0;
            rows_in    = 0;
            words_out  = 0;
            cfg_writes = 0;
        endfunction

        // zero counts as one; the count saturates at the matrix depth
        function int unsigned state_count();
            int unsigned s;
            int unsigned n;
            s = (size_log == '0) ? 1 : size_log;
            n = 1 << s;
            if (n > MAX_STATES) begin
                n = MAX_STATES;
            end
            return n;
        endfunction

        // A register write drops any partly loaded matrix.
        function void note_config(logic [SB_W-1:0] v);
            size_log  = v;
            rows_held = 0;
            cfg_writes++;
        endfunction

        function void note_row(row_t r);
            int unsigned   n;
            row_t          mask;
            row_t          pivot;
            closure_word_t w;
            n    = state_count();
            mask = row_t'((32'd1 << n) - 32'd1);
            rows_in++;
            if (rows_held >= n) begin
                rows_held = 0;
            end
            adj[rows_held] = r & mask;
            rows_held++;
            if (rows_held < n) begin
                return;
            end
            // reflexive closure first, then one pivot per column
            for (int i = 0; i < n; i++) begin
                adj[i][i] = 1'b1;
            end
            for (int k = 0; k < n; k++) begin
                pivot = adj[k];
                for (int i = 0; i < n; i++) begin
                    if (adj[i][k]) begin
                        adj[i] = adj[i] | pivot;
                    end
                end
            end
            for (int i = 0; i < n; i++) begin
                w.reach = adj[i] & mask;
                w.src   = 4'(i);
                w.last  = (i == n - 1);
                reach_q.insert(reach_q.size(), w);
            end
            rows_held = 0;
        endfunction

        function void check_word(row_t row, logic [3:0] src, logic last);
            closure_word_t w;
            words_out++;
            if (reach_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected word: row %h index %0d last %0b",
                         $time, row, src, last);
                return;
            end
            w = reach_q.pop_front();
            if (row !== w.reach) begin
                errors++;
                $display("%0t: closure_row mismatch: expected %h, actual %h",
                         $time, w.reach, row);
            end
            if (src !== w.src) begin
                errors++;
                $display("%0t: row_index mismatch: expected %0d, actual %0d",
                         $time, w.src, src);
            end
            if (last !== w.last) begin
                errors++;
                $display("%0t: last_row mismatch: expected %0b, actual %0b",
                         $time, w.last, last);
            end
        endfunction
    endclass

    logic            aclk           = 1'b0;
    logic            aresetn        = 1'b0;
    logic            cfg_valid      = 1'b0;
    logic            cfg_ready;
    logic [SB_W-1:0] cfg_state_bits = '0;
    logic            s_valid        = 1'b0;
    logic            s_ready;
    logic [15:0]     s_row_bits     = '0;
    logic            m_valid;
    logic            m_ready        = 1'b0;
    logic [15:0]     m_closure_row;
    logic [3:0]      m_row_index;
    logic            m_last_row;

    int unsigned  snd_idle = 0;
    int unsigned  rcv_idle = 0;
    int unsigned  quiet    = 0;
    closure_board board    = new();

    boolean_transitive_closure uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_state_bits(cfg_state_bits),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_row_bits    (s_row_bits),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_closure_row (m_closure_row),
        .m_row_index   (m_row_index),
        .m_last_row    (m_last_row)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Stall the result channel at random.
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= rcv_idle);
    end

    // Check every closure word as it is taken.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            board.check_word(m_closure_row, m_row_index, m_last_row);
        end
    end

    // End the run when no channel moves a word for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)
                || (cfg_valid && cfg_ready)) begin
            quiet <= 0;
        end else begin
            quiet <= quiet + 1;
            if (quiet >= WATCHDOG_LIMIT) begin
                $display("%0t: watchdog: no word moved for %0d cycles", $time, quiet);
                $display("tb_top failed");
                $finish;
            end
        end
    end

    // Offer one row; hold it until the block takes it.
    task automatic send_row(input row_t r);
        while ($urandom_range(0, 99) < snd_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_row_bits <= r;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        board.note_row(r);
    endtask

    task automatic write_cfg(input logic [SB_W-1:0] v);
        cfg_valid      <= 1'b1;
        cfg_state_bits <= v;
        do begin
            @(posedge aclk);
        end while (!cfg_ready);
        board.note_config(v);
        cfg_valid <= 1'b0;
    endtask

    // Hold the sender until every owed word is out, then let the block settle.
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (board.reach_q.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Mostly sparse rows so closures take several pivots; some dense or
    // full-width rows to hit the masking of columns beyond the state count.
    function automatic row_t rand_row(input int unsigned n);
        row_t        r;
        int unsigned pick;
        r    = '0;
        pick = $urandom_range(0, 9);
        case (pick)
            0: begin
                r = '0;
            end
            9: begin
                r = '1;
            end
            6, 7, 8: begin
                r = row_t'($urandom);
            end
            default: begin
                r[$urandom_range(0, n - 1)] = 1'b1;
                if ($urandom_range(0, 1) == 1) begin
                    r[$urandom_range(0, n - 1)] = 1'b1;
                end
                if ($urandom_range(0, 3) == 0) begin
                    r[$urandom_range(0, ROW_W - 1)] = 1'b1;
                end
            end
        endcase
        return r;
    endfunction

    initial begin
        int unsigned     n;
        int unsigned     phase_rows;
        int unsigned     seg;
        logic [SB_W-1:0] sb;

        seg = 0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset size of 16 states: a single ring reaches everything
        for (int i = 0; i < 16; i++) begin
            send_row(row_t'(1) << ((i + 1) % 16));
        end

        // size code zero acts as two states; high columns get masked
        wait_idle();
        write_cfg(SB_W'(0));
        send_row(16'hFFFF);
        send_row(16'h0000);

        // four-state chain 0 -> 1 -> 2 -> 3
        wait_idle();
        write_cfg(SB_W'(2));
        send_row(16'h0002);
        send_row(16'h0004);
        send_row(16'h0008);
        send_row(16'h0000);

        // partial eight-state matrix, dropped by the next register write
        wait_idle();
        write_cfg(SB_W'(3));
        send_row(16'h00F0);
        send_row(16'h8001);
        send_row(16'h0003);

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    snd_idle = 31;
                    rcv_idle = 48;
                end
                1: begin
                    snd_idle = 48;
                    rcv_idle = 31;
                end
                default: begin
                    snd_idle = 0;
                    rcv_idle = 0;
                end
            endcase
            phase_rows = 0;
            while (phase_rows < PHASE_ROWS) begin
                // walk every size code once, then pick at random
                wait_idle();
                sb = (seg < 8) ? SB_W'(seg) : SB_W'($urandom_range(0, 7));
                seg++;
                write_cfg(sb);
                n = board.state_count();
                repeat ($urandom_range(1, 4)) begin
                    for (int i = 0; i < n; i++) begin
                        send_row(rand_row(n));
                        phase_rows++;
                    end
                end
                // now and then leave a matrix unfinished
                if ($urandom_range(0, 5) == 0) begin
                    repeat ($urandom_range(1, n - 1)) begin
                        send_row(rand_row(n));
                        phase_rows++;
                    end
                end
            end
        end

        wait_idle();
        $display("Loaded %0d rows over %0d size settings (2 to 16 states), three idle mixes.",
                 board.rows_in, board.cfg_writes);
        $display("Checked %0d closure words, %0d mismatches.",
                 board.words_out, board.errors);
        if (board.errors == 0 && board.reach_q.size() == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule
